[rtl/assert_macros.svh]
// Assertion macros for the RTL of the hash set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion, disabled while reset is asserted
`define LPHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hash set assertion failed");

// Clocked assertion that is also checked during reset
`define LPHS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("hash set assertion failed");

`else

`define LPHS_ASSERT(lbl, prop)
`define LPHS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[rtl/lphs_pkg.sv]
// Package of types and constants for the linear probing hash set.
`timescale 1ns / 1ps

package lphs_pkg;

  // Fixed field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TOTAL_W  = 11;

  // Default table size, log2 of the slot count
  localparam int unsigned LOG_SLOTS_DEF = 10;

  // Load limit: refuse a new key when LOAD_DEN * n > LOAD_NUM * (slots - 1)
  localparam int unsigned LOAD_NUM = 9;
  localparam int unsigned LOAD_DEN = 10;

  // Request operation codes
  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_TEST = 1'b1
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_FULL     = 3'd3,
    ST_MARKER   = 3'd4
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_e;

endpackage

[rtl/lphs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module lphs_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered on the read enable
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/linear_probing_hash_set.sv]
// Top level of the linear probing hash set: controller, slot memory, result register.
//
// Set of 64-bit keys in a table of 2**LOG_SLOTS slots. A key's home slot is its
// low LOG_SLOTS bits; probing steps to the next slot with wrap-around. Each slot
// lives in one word of a single slot memory as {occupied, key}. After reset the
// block runs a clearing pass over the slot memory, one slot per cycle, that
// frees every slot; in_ready_o stays low during the pass while configuration
// writes are taken as usual. One request is in work at a time: a request whose
// key equals the empty marker goes straight to the done state; any other first
// probes from its home slot until a hit, a free slot or every slot has been
// probed, then waits in the done state until the output register is free and
// loads its result there. in_ready_o returns in the cycle after the load; a
// result still waiting in the output register holds the next request
// in its done state until it is taken. The probe rate of one slot per cycle is
// set by the single read port of the slot memory. An insert is written back in
// the cycle that ends the probe run. The result sits in an output register, so
// the next word can be accepted while the previous result waits to be taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_probing_hash_set
  import lphs_pkg::*;
#(
  parameter int unsigned LOG_SLOTS = LOG_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: empty marker
  input  logic                cfg_we_i,
  input  logic [KEY_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [KEY_W-1:0]    key_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [TOTAL_W-1:0]  entry_total_o
);

  localparam int unsigned SlotCount = 2 ** LOG_SLOTS;
  localparam int unsigned CntW      = LOG_SLOTS + 1;
  localparam int unsigned WordW     = KEY_W + 1;
  localparam int unsigned LoadLimit = (LOAD_NUM * (SlotCount - 1)) / LOAD_DEN;

  // Control registers
  state_e                state_q, state_d;
  logic [LOG_SLOTS-1:0]  clr_q, clr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [KEY_W-1:0]      marker_q;
  logic                  out_valid_q, out_valid_d;

  // Request and result payload registers
  logic                  func_q, func_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [LOG_SLOTS-1:0]  idx_q, idx_d;
  logic [LOG_SLOTS-1:0]  steps_q, steps_d;
  status_e               res_q, res_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [TOTAL_W-1:0]    total_q, total_d;

  // Slot memory ports
  logic                  ram_we;
  logic [LOG_SLOTS-1:0]  ram_waddr;
  logic [WordW-1:0]      ram_wdata;
  logic                  ram_re;
  logic [LOG_SLOTS-1:0]  ram_raddr;
  logic [WordW-1:0]      ram_rdata;

  // Probe decode
  logic                  rd_used;
  logic [KEY_W-1:0]      rd_key;
  logic                  hit, slot_free, last_probe, probe_end, at_limit;
  logic                  in_acc, is_marker, out_load;
  logic [31:0]           cnt_ext;

  lphs_ram #(
    .WIDTH (WordW),
    .DEPTH (SlotCount)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_used    = ram_rdata[KEY_W];
  assign rd_key     = ram_rdata[KEY_W-1:0];
  assign hit        = rd_used && (rd_key == key_q);
  assign slot_free  = !rd_used;
  assign last_probe = &steps_q;
  assign probe_end  = hit || slot_free || last_probe;
  assign at_limit   = (count_q >= CntW'(LoadLimit));

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_marker  = (key_i == marker_q);
  assign out_load   = !out_valid_q || out_ready_i;
  assign cnt_ext    = 32'(count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_d = is_marker ? S_DONE : S_PROBE;
      end
      S_PROBE: begin
        if (probe_end) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Datapath, memory control and result register
  always_comb begin
    clr_d       = clr_q;
    count_d     = count_q;
    func_d      = func_q;
    key_d       = key_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    res_d       = res_q;
    status_d    = status_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {1'b1, key_q};
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    case (state_q)
      S_CLEAR: begin
        // sweep every slot to free
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          func_d    = func_i;
          key_d     = key_i;
          idx_d     = key_i[LOG_SLOTS-1:0];
          steps_d   = '0;
          res_d     = ST_MARKER;
          // home slot read
          ram_re    = !is_marker;
          ram_raddr = key_i[LOG_SLOTS-1:0];
        end
      end
      S_PROBE: begin
        if (probe_end) begin
          if (hit) begin
            res_d = ST_PRESENT;
          end else if (func_q == FUNC_TEST) begin
            res_d = ST_ABSENT;
          end else if (!slot_free || at_limit) begin
            res_d = ST_FULL;
          end else begin
            // claim the free slot
            res_d   = ST_INSERTED;
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end else begin
          // next slot, wrapping at the end of the table
          idx_d     = idx_q + 1'b1;
          steps_d   = steps_q + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          status_d    = res_q;
          total_d     = cnt_ext[TOTAL_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      marker_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) marker_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    steps_q  <= steps_d;
    res_q    <= res_d;
    status_q <= status_d;
    total_q  <= total_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_total_o = total_q;

  // Load never passes the limit
  `LPHS_ASSERT(a_count_limit, count_q <= CntW'(LoadLimit))
  // A write during a probe is always an insert that bumps the count
  `LPHS_ASSERT(a_insert_count, (state_q == S_PROBE && ram_we) |=> count_q == $past(count_q) + 1'b1)
  // No request is taken during the clearing pass
  `LPHS_ASSERT_ALWAYS(a_clear_blocks, (state_q == S_CLEAR) |-> !in_ready_o)
  // A result is loaded only from the done state
  `LPHS_ASSERT(a_load_from_done, !out_valid_q |=> (!out_valid_o || $past(state_q) == S_DONE))

endmodule

[bench/linear_probing_hash_set_tb.sv]
// Self-checking testbench for the linear probing hash set: shadow table, driver and monitor.
`timescale 1ns / 1ps

module linear_probing_hash_set_tb;
  import lphs_pkg::*;

  localparam int unsigned SLOTS = 1 << LOG_SLOTS_DEF;

  typedef struct packed {
    func_e            op;
    logic [KEY_W-1:0] key;
  } set_req_t;

  typedef struct packed {
    status_e            status;
    logic [TOTAL_W-1:0] total;
  } set_result_t;

  // DUT inputs, all at known values from time zero
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [KEY_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                func_i = 1'b0;
  logic [KEY_W-1:0]    key_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [TOTAL_W-1:0]  entry_total_o;

  // Shadow copy of the table and the marker register
  logic [KEY_W-1:0] shadow_key [SLOTS];
  bit               shadow_used [SLOTS];
  int unsigned      shadow_count = 0;
  logic [KEY_W-1:0] shadow_marker = '0;

  set_req_t         pending_words[$];
  set_result_t      pending_results[$];
  logic [KEY_W-1:0] issued_keys[$];

  int send_idle_pct = 37;
  int recv_idle_pct = 64;
  int fail_count    = 0;
  int results_seen  = 0;
  int hold_left     = 0;

  linear_probing_hash_set u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_total_o (entry_total_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Probe the shadow table for one request and apply it; returns the expected word
  function automatic set_result_t probe_and_update(func_e op, logic [KEY_W-1:0] k);
    set_result_t r;
    int unsigned idx;
    bit          found;
    bit          has_free;
    found    = 1'b0;
    has_free = 1'b0;
    if (k == shadow_marker) begin
      r.status = ST_MARKER;
    end else begin
      idx = int'(k[LOG_SLOTS_DEF-1:0]);
      for (int unsigned n = 0; n < SLOTS; n++) begin
        if (!shadow_used[idx]) begin
          has_free = 1'b1;
          break;
        end
        if (shadow_key[idx] == k) begin
          found = 1'b1;
          break;
        end
        idx = (idx + 1) % SLOTS;
      end
      if (found) begin
        r.status = ST_PRESENT;
      end else if (op == FUNC_TEST) begin
        r.status = ST_ABSENT;
      end else if (!has_free ||
                   LOAD_DEN * (shadow_count + 1) > LOAD_NUM * (SLOTS - 1)) begin
        r.status = ST_FULL;
      end else begin
        shadow_key[idx]  = k;
        shadow_used[idx] = 1'b1;
        shadow_count++;
        r.status = ST_INSERTED;
      end
    end
    r.total = shadow_count[TOTAL_W-1:0];
    return r;
  endfunction

  // Random key; now and then it shares its home slot with an earlier key
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] peer;
    k = {$urandom, $urandom};
    if (issued_keys.size() != 0 && $urandom_range(9) == 0) begin
      peer = issued_keys[$urandom_range(issued_keys.size() - 1)];
      k[LOG_SLOTS_DEF-1:0] = peer[LOG_SLOTS_DEF-1:0];
    end
    return k;
  endfunction

  task automatic push_word(input func_e op, input logic [KEY_W-1:0] k);
    set_req_t w;
    w.op  = op;
    w.key = k;
    pending_words.push_back(w);
  endtask

  // Mostly adds of new keys; the rest are marker hits, misses and repeats
  task automatic queue_random(input int n, input int add_pct);
    int               r;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        push_word(func_e'($urandom_range(1)), shadow_marker);
      end else if (r < 2 + add_pct) begin
        k = fresh_key();
        issued_keys.push_back(k);
        push_word(FUNC_ADD, k);
      end else if (r[0] || issued_keys.size() == 0) begin
        push_word(FUNC_TEST, fresh_key());
      end else begin
        push_word(func_e'($urandom_range(1)),
                  issued_keys[$urandom_range(issued_keys.size() - 1)]);
      end
    end
  endtask

  // Wait at the falling edge until every word is sent and answered
  task automatic drain();
    @(negedge clk_i);
    while (pending_words.size() != 0 || pending_results.size() != 0 || in_valid_i)
      @(negedge clk_i);
  endtask

  // Marker write, only with the block idle
  task automatic set_marker(input logic [KEY_W-1:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v;
    shadow_marker = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Request driver: predicts on acceptance, then offers the next word
  always @(posedge clk_i) begin
    set_req_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        pending_results.push_back(probe_and_update(func_e'(func_i), key_i));
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          func_i     <= w.op;
          key_i      <= w.key;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random and long back-pressure
  always @(posedge clk_i) begin
    set_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            fail_count++;
          end
          if (entry_total_o !== exp_r.total) begin
            $error("entry_total: expected %0d, got %0d", exp_r.total, entry_total_o);
            fail_count++;
          end
        end
        // long hold-off so the block fills and stalls its input
        if (results_seen == 500 || results_seen == 1000)
          hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned cap;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // marker at its reset value of zero
    push_word(FUNC_TEST, 64'h0);
    push_word(FUNC_ADD,  64'h0);
    push_word(FUNC_TEST, '1);
    push_word(FUNC_ADD,  '1);
    push_word(FUNC_ADD,  '1);
    push_word(FUNC_TEST, '1);
    // collisions around the top slot, wrapping to the bottom
    push_word(FUNC_ADD,  64'h7FF);
    push_word(FUNC_ADD,  64'h400);
    push_word(FUNC_ADD,  64'h1);
    push_word(FUNC_TEST, 64'hBFF);
    push_word(FUNC_TEST, 64'h1);
    push_word(FUNC_ADD,  64'h8000_0000_0000_0000);
    push_word(FUNC_ADD,  64'h5555_5555_5555_5555);
    push_word(FUNC_ADD,  64'hAAAA_AAAA_AAAA_AAAA);
    push_word(FUNC_TEST, 64'h5555_5555_5555_5554);

    // marker moved onto a stored key; zero becomes a normal key
    set_marker('1);
    push_word(FUNC_TEST, '1);
    push_word(FUNC_ADD,  '1);
    push_word(FUNC_ADD,  64'h0);
    push_word(FUNC_TEST, 64'h0);

    set_marker({$urandom, $urandom});
    queue_random(300, 90);

    drain();
    send_idle_pct = 64;
    recv_idle_pct = 37;
    set_marker('0);
    queue_random(300, 90);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_marker({$urandom, $urandom});
    queue_random(150, 80);

    // sender pause, then fill the table to its load limit and beyond
    drain();
    cap = shadow_count;
    while (LOAD_DEN * (cap + 1) <= LOAD_NUM * (SLOTS - 1))
      cap++;
    queue_random((cap - shadow_count) * 6 / 5 + 60, 90);

    // at the limit: repeat add, lookup, and a refused new key
    drain();
    push_word(FUNC_ADD,  64'h7FF);
    push_word(FUNC_TEST, 64'h7FF);
    push_word(FUNC_ADD,  fresh_key());

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
